/* src/dbf_pkg.sv */
// shared types, constants and operation codes for the double-ended bit fifo
package dbf_pkg;

    localparam int CAPACITY  = 256;
    localparam int WORD_BITS = 64;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 64;
    localparam int NUM_W   = 7;
    localparam int BCNT_W  = 9;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W   = $clog2(2 * CAPACITY);
    localparam int IDX_W   = $clog2(VALUE_W);

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [VALUE_W-1:0] value;
        logic [NUM_W-1:0]   num_bits;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [BCNT_W-1:0]  bit_count;
        logic               error;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic commit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic nop;
        logic err;
        logic is_loop;
        logic is_push;
        logic is_read;
        logic last;
    } t_stat;

endpackage

/* src/dbf_ifs.sv */
// request and response channel interfaces
interface dbf_req_if;
    import dbf_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dbf_rsp_if;
    import dbf_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* src/dbf_datapath.sv */
// bit store, pointers, counters and result registers of the bit fifo
module dbf_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dbf_pkg::t_req  i_item,
    input  dbf_pkg::t_cmd  i_cmd,
    output dbf_pkg::t_stat o_stat,
    output dbf_pkg::t_rsp  o_item
);
    import dbf_pkg::*;

    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] cap;
        cap = SUM_W'(CAPACITY);
        if (x >= cap) begin
            return ADDR_W'(x - cap);
        end
        return ADDR_W'(x);
    endfunction

    function automatic logic [ADDR_W-1:0] inc_addr(input logic [ADDR_W-1:0] a);
        if (a == ADDR_W'(CAPACITY - 1)) begin
            return '0;
        end
        return a + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] dec_addr(input logic [ADDR_W-1:0] a);
        if (a == '0) begin
            return ADDR_W'(CAPACITY - 1);
        end
        return a - 1'b1;
    endfunction

    logic               mem [CAPACITY];
    logic               r_q;

    logic [OP_W-1:0]    r_op;
    logic [VALUE_W-1:0] r_val;
    logic [NUM_W-1:0]   r_n;
    logic [ADDR_W-1:0]  r_head;
    logic [COUNT_W-1:0] r_count;
    logic [ADDR_W-1:0]  r_ptr;
    logic [IDX_W-1:0]   r_k;
    logic [VALUE_W-1:0] r_rd;
    logic               r_err;
    logic               r_cap_en;
    logic [IDX_W-1:0]   r_cap_idx;

    logic [VALUE_W-1:0] r_o_rd;
    logic [BCNT_W-1:0]  r_o_cnt;
    logic               r_o_err;

    logic               op_ok;
    logic               is_push;
    logic               is_peek;
    logic               nop;
    logic               too_wide;
    logic [COUNT_W:0]   sum_push;
    logic               overflow;
    logic               underflow;
    logic               err;
    logic [SUM_W-1:0]   tail_raw;
    logic [SUM_W-1:0]   back_raw;
    logic [SUM_W-1:0]   front_raw;
    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W-1:0]   rev_idx;
    logic               wr_bit;

    always_comb begin
        op_ok     = (r_op <= OP_PEEK_BACK);
        is_push   = (r_op == OP_PUSH_BACK) || (r_op == OP_PUSH_FRONT);
        is_peek   = (r_op == OP_PEEK_FRONT) || (r_op == OP_PEEK_BACK);
        nop       = !op_ok || (r_n == '0);
        too_wide  = (r_n > NUM_W'(WORD_BITS));
        sum_push  = (COUNT_W+1)'(r_count) + (COUNT_W+1)'(r_n);
        overflow  = (sum_push > (COUNT_W+1)'(CAPACITY));
        underflow = (COUNT_W'(r_n) > r_count);
        err       = !nop && (too_wide || (is_push ? overflow : underflow));
        tail_raw  = SUM_W'(r_head) + SUM_W'(r_count);
        back_raw  = tail_raw - SUM_W'(r_n);
        front_raw = SUM_W'(r_head) + SUM_W'(r_n);
        last_idx  = IDX_W'(r_n - 1'b1);
        rev_idx   = last_idx - r_k;
        wr_bit    = (r_op == OP_PUSH_FRONT) ? r_val[rev_idx] : r_val[r_k];
    end

    assign o_stat.nop     = nop;
    assign o_stat.err     = err;
    assign o_stat.is_loop = is_push || is_peek;
    assign o_stat.is_push = is_push;
    assign o_stat.is_read = is_peek;
    assign o_stat.last    = (r_k == last_idx);

    // single-port bit store
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && is_push) begin
            mem[r_ptr] <= wr_bit;
        end
        r_q <= mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_item.operation;
            r_val <= i_item.value;
            r_n   <= i_item.num_bits;
        end
        if (i_cmd.setup) begin
            r_k   <= '0;
            r_err <= err;
            case (r_op)
                OP_PUSH_BACK:  r_ptr <= wrap_addr(tail_raw);
                OP_PUSH_FRONT: r_ptr <= dec_addr(r_head);
                OP_PEEK_BACK:  r_ptr <= wrap_addr(back_raw);
                default:       r_ptr <= r_head;
            endcase
        end else if (i_cmd.step) begin
            r_k <= r_k + 1'b1;
            if (r_op == OP_PUSH_FRONT) begin
                r_ptr <= dec_addr(r_ptr);
            end else begin
                r_ptr <= inc_addr(r_ptr);
            end
        end
        if (i_cmd.setup) begin
            r_rd <= '0;
        end else if (r_cap_en) begin
            r_rd[r_cap_idx] <= r_q;
        end
        r_cap_idx <= r_k;
        if (i_cmd.finish) begin
            r_o_rd  <= r_rd;
            r_o_cnt <= BCNT_W'(r_count);
            r_o_err <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_cap_en <= 1'b0;
        end else begin
            r_cap_en <= i_cmd.step && is_peek;
            if (i_cmd.setup && !nop && !err) begin
                if (r_op == OP_POP_BACK) begin
                    r_count <= r_count - COUNT_W'(r_n);
                end else if (r_op == OP_POP_FRONT) begin
                    r_count <= r_count - COUNT_W'(r_n);
                    r_head  <= wrap_addr(front_raw);
                end
            end
            if (i_cmd.step && (r_op == OP_PUSH_FRONT)) begin
                r_head <= r_ptr;
            end
            if (i_cmd.commit) begin
                r_count <= COUNT_W'(sum_push);
            end
        end
    end

    assign o_item.read_value = r_o_rd;
    assign o_item.bit_count  = r_o_cnt;
    assign o_item.error      = r_o_err;

endmodule

/* src/dbf_ctrl.sv */
// sequencing state machine of the bit fifo
module dbf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    input  dbf_pkg::t_stat i_stat,
    output dbf_pkg::t_cmd  o_cmd
);
    import dbf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_full;
    logic       n_out_full;
    logic       slot_free;

    assign slot_free = !r_out_full || i_rsp_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_req_ready  = 1'b0;
        n_out_full   = r_out_full && !i_rsp_ready;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_stat.nop || i_stat.err || !i_stat.is_loop) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) begin
                    o_cmd.commit = i_stat.is_push;
                    n_state      = i_stat.is_read ? S_FLUSH : S_FIN;
                end
            end
            S_FLUSH: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_full   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_full <= n_out_full;
        end
    end

    assign o_rsp_valid = r_out_full;

endmodule

/* src/double_ended_bit_fifo.sv */
// top level of the double-ended bit fifo
//
//   channel   direction  carries
//   i_req     in         operation, value, num_bits
//   o_rsp     out        read_value, bit_count, error
//
// pops, zero-width and refused requests go from setup straight to finish
// pushes and peeks move one bit per cycle, a peek with an extra flush state,
// through the single-port bit store
// a finished item waits in the output register while the next is accepted
// synchronous active-low reset empties the fifo; stored bits are not cleared
module double_ended_bit_fifo (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dbf_req_if.sink   i_req,
    dbf_rsp_if.source o_rsp
);
    import dbf_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  req_ready;
    logic  rsp_valid;
    t_rsp  rsp_item;

    dbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dbf_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_req.payload),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_item  (rsp_item)
    );

    assign i_req.ready   = req_ready;
    assign o_rsp.valid   = rsp_valid;
    assign o_rsp.payload = rsp_item;

endmodule

/* sim/tb_double_ended_bit_fifo.sv */
// testbench for the double-ended bit fifo: directed and random operations checked bit by bit
module tb_double_ended_bit_fifo;
    import dbf_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
    localparam int RANDOM_OPS  = 600;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 500000;

    typedef struct {
        t_req req;
        bit   wait_drained;
    } t_fifo_op;

    logic i_clk;
    logic i_rst_n;

    dbf_req_if req_ch ();
    dbf_rsp_if rsp_ch ();

    double_ended_bit_fifo dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_fifo_op pending_ops[$];
    t_rsp     fifo_replies[$];

    logic [CAPACITY-1:0] shadow_bits = '0;
    int unsigned         shadow_len = 0;

    bit       go = 0;
    bit       offering = 0;
    bit       hold_done = 0;
    logic     req_took = 0;
    t_fifo_op cur_op;
    int       send_gap = 0;
    int       take_gap = 0;
    int       hold_left = 0;
    int       sent_cnt = 0;
    int       req_cnt = 0;
    int       rsp_cnt = 0;
    int       cycle_cnt = 0;
    int       mismatch_cnt = 0;
    int       n_items = 0;

    function automatic t_rsp shadow_fifo_op(t_req r);
        t_rsp        o;
        int unsigned n;
        n = 32'(r.num_bits);
        o = '0;
        if (r.operation <= OP_PEEK_BACK && n != 0) begin
            if (n > WORD_BITS) begin
                o.error = 1'b1;
            end else if (r.operation == OP_PUSH_BACK || r.operation == OP_PUSH_FRONT) begin
                if (shadow_len + n > CAPACITY) begin
                    o.error = 1'b1;
                end else begin
                    if (r.operation == OP_PUSH_BACK) begin
                        for (int i = 0; i < n; i++) shadow_bits[shadow_len + i] = r.value[i];
                    end else begin
                        shadow_bits = shadow_bits << n;
                        for (int i = 0; i < n; i++) shadow_bits[i] = r.value[i];
                    end
                    shadow_len += n;
                end
            end else if (n > shadow_len) begin
                o.error = 1'b1;
            end else begin
                case (r.operation)
                    OP_POP_BACK: begin
                        shadow_len -= n;
                    end
                    OP_POP_FRONT: begin
                        shadow_bits = shadow_bits >> n;
                        shadow_len -= n;
                    end
                    OP_PEEK_FRONT: begin
                        for (int i = 0; i < n; i++) o.read_value[i] = shadow_bits[i];
                    end
                    default: begin
                        for (int i = 0; i < n; i++)
                            o.read_value[i] = shadow_bits[shadow_len - n + i];
                    end
                endcase
            end
        end
        o.bit_count = shadow_len[BCNT_W-1:0];
        return o;
    endfunction

    task automatic queue_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                            logic [NUM_W-1:0] n, bit wait_drained);
        t_fifo_op item;
        item.req.operation = op;
        item.req.value     = value;
        item.req.num_bits  = n;
        item.wait_drained  = wait_drained;
        pending_ops = {pending_ops, item};
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // sender
    always @(negedge i_clk) begin
        if (go) begin
            if (offering && req_took) begin
                offering = 0;
                sent_cnt++;
                if (sent_cnt < n_items - 80 && (sent_cnt / 100) % 3 != 2 &&
                    $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 18);
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() != 0 &&
                             !(pending_ops[0].wait_drained && fifo_replies.size() != 0)) begin
                    cur_op = pending_ops[0];
                    pending_ops.delete(0);
                    offering = 1;
                end
            end
            req_ch.valid <= offering;
            if (offering) req_ch.payload <= cur_op.req;
        end else begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= '0;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (go) begin
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!hold_done && req_cnt >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                rsp_ch.ready <= 1'b0;
            end else if (rsp_cnt < n_items - 80 && (rsp_cnt / 100) % 3 != 1 &&
                         $urandom_range(0, 9) == 0) begin
                take_gap = $urandom_range(1, 18) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end else begin
            rsp_ch.ready <= 1'b0;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_rsp want;
        cycle_cnt++;
        req_took <= req_ch.valid && req_ch.ready;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_cnt++;
            if (fifo_replies.size() == 0) begin
                $error("unexpected item: read_value %h bit_count %0d error %b",
                       rsp_ch.payload.read_value, rsp_ch.payload.bit_count,
                       rsp_ch.payload.error);
                mismatch_cnt++;
            end else begin
                want = fifo_replies[0];
                fifo_replies.delete(0);
                if (rsp_ch.payload.read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h",
                           want.read_value, rsp_ch.payload.read_value);
                    mismatch_cnt++;
                end
                if (rsp_ch.payload.bit_count !== want.bit_count) begin
                    $error("bit_count: expected %0d, got %0d",
                           want.bit_count, rsp_ch.payload.bit_count);
                    mismatch_cnt++;
                end
                if (rsp_ch.payload.error !== want.error) begin
                    $error("error: expected %b, got %b", want.error, rsp_ch.payload.error);
                    mismatch_cnt++;
                end
            end
        end
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            want = shadow_fifo_op(req_ch.payload);
            fifo_replies = {fifo_replies, want};
            req_cnt++;
        end
    end

    initial begin
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [NUM_W-1:0]   n;
        int                 gen_len;
        int                 roll;
        int                 room;

        i_rst_n         = 1'b0;

        // directed part
        queue_op(OP_PUSH_BACK,  64'hFFFF_FFFF_FFFF_FFFF, 7'd0,   0);
        queue_op(OP_POP_FRONT,  64'h0,                   7'd1,   0);
        queue_op(OP_PEEK_BACK,  64'h0,                   7'd1,   0);
        queue_op(OP_PUSH_BACK,  64'hFFFF_FFFF_FFFF_FFFE, 7'd1,   0);
        queue_op(OP_PUSH_BACK,  64'h0000_0000_0000_0001, 7'd1,   0);
        queue_op(OP_PUSH_FRONT, 64'hA5A5_5A5A_0F0F_F0F0, 7'd64,  0);
        queue_op(OP_PUSH_BACK,  64'hFFFF_FFFF_FFFF_FFFF, 7'd64,  0);
        queue_op(OP_PUSH_BACK,  64'h0123_4567_89AB_CDEF, 7'd65,  0);
        queue_op(OP_PUSH_FRONT, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 0);
        queue_op(OP_PEEK_FRONT, 64'h0,                   7'd64,  0);
        queue_op(OP_PEEK_BACK,  64'h0,                   7'd64,  0);
        queue_op(OP_PEEK_FRONT, 64'h0,                   7'd0,   0);
        queue_op(OP_UNUSED_6,   64'hFFFF_FFFF_FFFF_FFFF, 7'd5,   0);
        queue_op(OP_UNUSED_7,   64'h0123_4567_89AB_CDEF, 7'd64,  0);
        queue_op(OP_PUSH_FRONT, 64'h0,                   7'd64,  0);
        queue_op(OP_PUSH_BACK,  64'h0123_4567_89AB_CDEF, 7'd62,  0);
        queue_op(OP_PUSH_BACK,  64'h1,                   7'd1,   0);
        queue_op(OP_PUSH_FRONT, 64'h1,                   7'd1,   0);
        queue_op(OP_PEEK_BACK,  64'h0,                   7'd3,   0);
        queue_op(OP_POP_BACK,   64'h0,                   7'd64,  0);
        queue_op(OP_POP_FRONT,  64'h0,                   7'd64,  0);
        queue_op(OP_PEEK_FRONT, 64'h0,                   7'd65,  0);
        queue_op(OP_POP_BACK,   64'h0,                   7'd64,  0);
        queue_op(OP_POP_FRONT,  64'hFFFF_FFFF_FFFF_FFFF, 7'd64,  0);
        queue_op(OP_PEEK_FRONT, 64'h0,                   7'd1,   0);

        // random part, kept mostly within the legal fill range
        gen_len = 0;
        for (int k = 0; k < RANDOM_OPS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                op = (roll == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
            end else begin
                op = OP_W'($urandom_range(0, 5));
                if (gen_len < 40 && op >= OP_POP_BACK && $urandom_range(0, 1) == 1)
                    op = OP_W'($urandom_range(0, 1));
                if (gen_len > 216 && op <= OP_PUSH_FRONT && $urandom_range(0, 1) == 1)
                    op = OP_W'($urandom_range(2, 3));
            end
            room = (op <= OP_PUSH_FRONT) ? CAPACITY - gen_len : gen_len;
            if (room > WORD_BITS) room = WORD_BITS;
            if (room < 1) room = 1;
            if ($urandom_range(0, 9) == 0)
                n = NUM_W'($urandom_range(0, 127));
            else if ($urandom_range(0, 1) == 1)
                n = NUM_W'($urandom_range(1, (room < 16) ? room : 16));
            else
                n = NUM_W'($urandom_range(1, room));
            value = {$urandom, $urandom};
            queue_op(op, value, n, k == 0 || k == RANDOM_OPS / 2);
            if (op <= OP_POP_FRONT && n != 0 && n <= WORD_BITS) begin
                if (op <= OP_PUSH_FRONT) begin
                    if (gen_len + int'(n) <= CAPACITY) gen_len += int'(n);
                end else if (int'(n) <= gen_len) begin
                    gen_len -= int'(n);
                end
            end
        end
        n_items = pending_ops.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);
        go = 1;

        while (!(pending_ops.size() == 0 && !offering && fifo_replies.size() == 0) &&
               cycle_cnt < LIMIT)
            @(negedge i_clk);

        if (cycle_cnt >= LIMIT) begin
            $display("FAIL double_ended_bit_fifo");
        end else begin
            repeat (20) @(negedge i_clk);
            if (mismatch_cnt == 0 && fifo_replies.size() == 0)
                $display("PASS double_ended_bit_fifo");
            else
                $display("FAIL double_ended_bit_fifo");
        end
        $finish;
    end

endmodule
